FILE: rtl/sgd_pkg.sv
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types and constants for the swipe gesture detector: register
// indexes, reset values, field widths and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sgd_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_WINDOW_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int STAMP_W      = 32;
  localparam int WINDOW_LEN_W = 6;
  localparam int LENGTH_W     = 12;
  localparam int DUR_W        = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  // Direction dead band, millimetres
  localparam int DEAD_BAND_MM = 10;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DUR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUR    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP    = 3'd5;

  // Register reset values
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RST = 6'd20;
  localparam logic [LENGTH_W-1:0]     MIN_LENGTH_RST = 12'd100;
  localparam logic [LENGTH_W-1:0]     MAX_HEIGHT_RST = 12'd200;
  localparam logic [DUR_W-1:0]        MIN_DUR_RST    = 16'd250;
  localparam logic [DUR_W-1:0]        MAX_DUR_RST    = 16'd1500;
  localparam logic [DUR_W-1:0]        MIN_GAP_RST    = 16'd100;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // take a new sample, set up the scan
    logic rd;     // read the next older sample, step the scan pointer
    logic cmp;    // compare the returned sample against the anchor
    logic emit;   // move the pending report into the output register
  } sgd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic left_zero;  // no more samples to read
    logic cmp_valid;  // read data is on the compare inputs
    logic hit;        // swipe found and reportable
    logic out_busy;   // output register holds an untaken result
  } sgd_sts_t;

endpackage

FILE: rtl/sgd_ctrl.sv
// ----------------------------------------------------------------------------
// sgd_ctrl
// Controller for the swipe gesture detector: takes a sample, runs the
// scan over older samples and hands a found swipe to the output register.
// ----------------------------------------------------------------------------
module sgd_ctrl
  import sgd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sgd_sts_t sts,
  output sgd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd  = !sts.left_zero;
        cmd.cmp = 1'b1;
        if (sts.hit) begin
          state_next = S_EMIT;
        end else if (sts.left_zero && !sts.cmp_valid) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sgd_dp.sv
// ----------------------------------------------------------------------------
// sgd_dp
// Datapath for the swipe gesture detector: configuration registers, the
// sample ring memory, anchor registers, compare logic and output register.
// ----------------------------------------------------------------------------
module sgd_dp
  import sgd_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sgd_cmd_t                     cmd,
  output sgd_sts_t                     sts,
  input  logic                         cfg_valid,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [STAMP_W-1:0]           stamp_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         direction,
  output logic [STAMP_W-1:0]           event_ms
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int WIN_W  = (CNT_W > WINDOW_LEN_W) ? CNT_W : WINDOW_LEN_W;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = (DIFF_W > LENGTH_W) ? DIFF_W : LENGTH_W;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_ONE   = WIN_W'(1);
  localparam logic signed [DIFF_W-1:0] NEG_BAND = DIFF_W'(-DEAD_BAND_MM);

  // Configuration registers
  logic [WINDOW_LEN_W-1:0] window_len;
  logic [LENGTH_W-1:0]     min_length_mm;
  logic [LENGTH_W-1:0]     max_height_mm;
  logic [DUR_W-1:0]        min_dur_ms;
  logic [DUR_W-1:0]        max_dur_ms;
  logic [DUR_W-1:0]        min_gap_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= WINDOW_LEN_RST;
      min_length_mm <= MIN_LENGTH_RST;
      max_height_mm <= MAX_HEIGHT_RST;
      min_dur_ms    <= MIN_DUR_RST;
      max_dur_ms    <= MAX_DUR_RST;
      min_gap_ms    <= MIN_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEN: window_len    <= cfg_data[WINDOW_LEN_W-1:0];
        REG_MIN_LENGTH: min_length_mm <= cfg_data[LENGTH_W-1:0];
        REG_MAX_HEIGHT: max_height_mm <= cfg_data[LENGTH_W-1:0];
        REG_MIN_DUR:    min_dur_ms    <= cfg_data[DUR_W-1:0];
        REG_MAX_DUR:    max_dur_ms    <= cfg_data[DUR_W-1:0];
        REG_MIN_GAP:    min_gap_ms    <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample ring
  logic signed [COORD_BITS-1:0] mem_x [MAX_WINDOW];
  logic signed [COORD_BITS-1:0] mem_y [MAX_WINDOW];
  logic [STAMP_W-1:0]           mem_t [MAX_WINDOW];

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] rd_addr;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] left;
  logic             cmp_valid;

  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic [STAMP_W-1:0]           rd_t;

  logic signed [COORD_BITS-1:0] anc_x;
  logic signed [COORD_BITS-1:0] anc_y;
  logic [STAMP_W-1:0]           anc_t;
  logic [STAMP_W-1:0]           now;
  logic [STAMP_W-1:0]           last_report_ms;
  logic                         gap_ok;
  logic                         dir_pend;

  // Window length for this frame
  logic [WIN_W-1:0] win_ext;
  logic [WIN_W-1:0] win_eff;
  logic [WIN_W-1:0] fill_ext;
  logic [WIN_W-1:0] scan_n;

  always_comb begin
    fill_inc = (fill == FULL) ? fill : fill + CNT_W'(1);
    win_ext  = WIN_W'(window_len);
    if (win_ext == '0) begin
      win_eff = WIN_ONE;
    end else if (win_ext > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = win_ext;
    end
    fill_ext = WIN_W'(fill_inc);
    scan_n   = (fill_ext < win_eff) ? fill_ext : win_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_x[head] <= pos_x;
      mem_y[head] <= pos_y;
      mem_t[head] <= stamp_ms;
    end
    if (cmd.rd) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_t <= mem_t[rd_addr];
    end
  end

  // Compare the returned sample with the anchor
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  logic [STAMP_W-1:0]       dt;
  logic                     far;
  logic                     long_enough;
  logic                     dur_ok;
  logic                     cmp_now;

  always_comb begin
    dx  = DIFF_W'(anc_x) - DIFF_W'(rd_x);
    dy  = DIFF_W'(anc_y) - DIFF_W'(rd_y);
    adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    dt  = anc_t - rd_t;
    far         = MAG_W'(ady) > MAG_W'(max_height_mm);
    long_enough = MAG_W'(adx) >= MAG_W'(min_length_mm);
    dur_ok      = (dt >= STAMP_W'(min_dur_ms)) && (dt < STAMP_W'(max_dur_ms));
    cmp_now     = cmd.cmp && cmp_valid;
  end

  assign sts.hit       = cmp_now && !far && long_enough && dur_ok && gap_ok;
  assign sts.left_zero = (left == '0);
  assign sts.cmp_valid = cmp_valid;
  assign sts.out_busy  = out_valid && !out_ready;

  // Scan control and anchor
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      fill           <= '0;
      left           <= '0;
      cmp_valid      <= 1'b0;
      last_report_ms <= '0;
    end else begin
      cmp_valid <= cmd.rd;
      if (cmd.load) begin
        head <= (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
        fill <= fill_inc;
        left <= CNT_W'(scan_n - WIN_ONE);
      end else if (cmd.rd) begin
        left <= left - CNT_W'(1);
      end
      if (sts.hit) begin
        last_report_ms <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      anc_x   <= pos_x;
      anc_y   <= pos_y;
      anc_t   <= stamp_ms;
      now     <= stamp_ms;
      gap_ok  <= (stamp_ms - last_report_ms) > STAMP_W'(min_gap_ms);
      // the sample one older than the one being written
      rd_addr <= (head == '0) ? LAST_SLOT : head - PTR_W'(1);
    end else if (cmd.rd) begin
      rd_addr <= (rd_addr == '0) ? LAST_SLOT : rd_addr - PTR_W'(1);
    end
    if (cmp_now && far) begin
      anc_x <= rd_x;
      anc_y <= rd_y;
      anc_t <= rd_t;
    end
    if (sts.hit) begin
      dir_pend <= !(dx > NEG_BAND);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      direction <= dir_pend;
      event_ms  <= now;
    end
  end

endmodule

FILE: rtl/swipe_gesture_detector.sv
// ----------------------------------------------------------------------------
// swipe_gesture_detector
// Detects left/right swipes of one tracked point from a stream of
// per-frame positions and timestamps.
// ----------------------------------------------------------------------------
// One sample (pos_x, pos_y in mm, stamp_ms) is taken per input transaction
// and stored in a ring of the newest MAX_WINDOW samples. The block then walks
// from the newest sample back through min(samples held, window_len) samples,
// one ring read per cycle, comparing each against an anchor that starts at
// the newest sample and jumps to any sample whose vertical drift from it
// exceeds max_height_mm. A sample with enough horizontal travel and a time
// span in [min_dur_ms, max_dur_ms) yields a swipe, reported only if more than
// min_gap_ms has passed since the previous report; at most one result per
// input. The sample ring has a single read port. The next input is taken
// once the scan ends; a finished result sits in an output register and
// only holds the block if a second result is ready before the first is
// taken. window_len of zero acts as one, values above MAX_WINDOW act as
// MAX_WINDOW. cfg_ready is always high; write configuration only while the
// block is idle.
module swipe_gesture_detector
  import sgd_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // sample input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [STAMP_W-1:0]           stamp_ms,
  // swipe report channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         direction,
  output logic [STAMP_W-1:0]           event_ms
);

  sgd_cmd_t cmd;
  sgd_sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequence the load, scan and report hand-off
  sgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the sample ring, anchor, compares and output register
  sgd_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .stamp_ms  (stamp_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .direction (direction),
    .event_ms  (event_ms)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for swipe_gesture_detector: frame streams of ramps,
// still hands, broken gestures, wrapping stamps and raw noise are pushed
// through the sample channel under random idling. A cycle-free predictor
// computes the swipe reports, and every report is checked on arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import sgd_pkg::*;

  localparam int RING_DEPTH     = MAX_WINDOW_DEF;
  localparam int SCAN_CYCLES    = 40;    // longest scan plus margin
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int NUM_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 150;

  typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_SPARSE} rx_mode_e;

  // Register write order for a full settings load
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER [6] = '{
    REG_WINDOW_LEN, REG_MIN_LENGTH, REG_MAX_HEIGHT,
    REG_MIN_DUR, REG_MAX_DUR, REG_MIN_GAP
  };

  // Settings per phase, in REG_ORDER:
  // window, min length, max height, min dur, max dur, min gap
  localparam logic [CFG_DATA_W-1:0] PHASE_SETTINGS [NUM_PHASES][6] = '{
    '{16'd32,     16'd100,  16'd200,  16'd250,   16'd1500,  16'd100},
    '{16'd2,      16'd0,    16'd4095, 16'd0,     16'd65535, 16'd0},
    '{16'hFFFF,   16'd4095, 16'd0,    16'd0,     16'd65535, 16'd65535},
    '{16'd0,      16'd50,   16'd100,  16'd100,   16'd1000,  16'd0},
    '{16'd8,      16'd0,    16'd50,   16'd500,   16'd400,   16'd0},
    '{16'd12,     16'd30,   16'd300,  16'd100,   16'd800,   16'd200},
    '{16'd33,     16'd200,  16'd4095, 16'd65535, 16'd65535, 16'd50},
    '{16'd20,     16'd0,    16'd4095, 16'd0,     16'd65535, 16'd0},
    '{16'd24,     16'd80,   16'd150,  16'd200,   16'd1200,  16'd50}
  };

  // --------------------------------------------------------------------------
  // Swipe predictor and report store
  // --------------------------------------------------------------------------
  class swipe_scoreboard;
    logic [WINDOW_LEN_W-1:0] window_len;
    logic [LENGTH_W-1:0]     min_length;
    logic [LENGTH_W-1:0]     max_height;
    logic [DUR_W-1:0]        min_dur;
    logic [DUR_W-1:0]        max_dur;
    logic [DUR_W-1:0]        min_gap;

    int              ring_x [RING_DEPTH];
    int              ring_y [RING_DEPTH];
    logic [31:0]     ring_t [RING_DEPTH];
    int              fill;
    int              head;
    logic [31:0]     last_report;

    logic            pending_dir [$];
    logic [31:0]     pending_event [$];

    int failures;
    int rights;
    int lefts;

    function new();
      window_len  = WINDOW_LEN_RST;
      min_length  = MIN_LENGTH_RST;
      max_height  = MAX_HEIGHT_RST;
      min_dur     = MIN_DUR_RST;
      max_dur     = MAX_DUR_RST;
      min_gap     = MIN_GAP_RST;
      foreach (ring_x[i]) begin
        ring_x[i] = 0;
        ring_y[i] = 0;
        ring_t[i] = '0;
      end
      fill        = 0;
      head        = 0;
      last_report = '0;
      failures    = 0;
      rights      = 0;
      lefts       = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_LEN: window_len = data[WINDOW_LEN_W-1:0];
        REG_MIN_LENGTH: min_length = data[LENGTH_W-1:0];
        REG_MAX_HEIGHT: max_height = data[LENGTH_W-1:0];
        REG_MIN_DUR:    min_dur    = data[DUR_W-1:0];
        REG_MAX_DUR:    max_dur    = data[DUR_W-1:0];
        REG_MIN_GAP:    min_gap    = data[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function int ring_slot(int k);
      return (head + 2 * RING_DEPTH - 1 - k) % RING_DEPTH;
    endfunction

    function int span(int a, int b);
      return (a >= b) ? a - b : b - a;
    endfunction

    // Store the sample, then walk back from the newest one looking for a swipe.
    function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic [31:0] t);
      int          win;
      int          n;
      int          a;
      int          s;
      int          d;
      logic [31:0] dt;
      logic [31:0] since;
      ring_x[head] = x;
      ring_y[head] = y;
      ring_t[head] = t;
      head = (head + 1) % RING_DEPTH;
      if (fill < RING_DEPTH) fill++;
      win = window_len;
      if (win < 1) win = 1;
      if (win > RING_DEPTH) win = RING_DEPTH;
      n = (fill < win) ? fill : win;
      a = ring_slot(0);
      for (int k = 1; k < n; k++) begin
        s = ring_slot(k);
        if (span(ring_y[a], ring_y[s]) > max_height) begin
          a = s;   // too much vertical drift: restart the gesture here
          continue;
        end
        if (span(ring_x[a], ring_x[s]) < min_length) continue;
        dt = ring_t[a] - ring_t[s];
        if (!(dt >= min_dur && dt < max_dur)) continue;
        since = t - last_report;
        if (since <= min_gap) continue;
        d = ring_x[a] - ring_x[s];
        pending_dir.push_back((d > -DEAD_BAND_MM) ? 1'b0 : 1'b1);
        pending_event.push_back(t);
        last_report = t;
        return;
      end
    endfunction

    function void check_report(logic dir, logic [31:0] ev);
      logic        want_dir;
      logic [31:0] want_ev;
      if (pending_dir.size() == 0) begin
        $display("%0t: unexpected report, direction %0d event_ms %0d", $time, dir, ev);
        failures++;
        return;
      end
      want_dir = pending_dir.pop_front();
      want_ev  = pending_event.pop_front();
      if (dir !== want_dir) begin
        $display("%0t: direction expected %0d actual %0d", $time, want_dir, dir);
        failures++;
      end
      if (ev !== want_ev) begin
        $display("%0t: event_ms expected %0d actual %0d", $time, want_ev, ev);
        failures++;
      end
      if (want_dir) lefts++;
      else rights++;
    endfunction

    function int outstanding();
      return pending_dir.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic                    rst       = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [15:0]      pos_x     = '0;
  logic signed [15:0]      pos_y     = '0;
  logic [STAMP_W-1:0]      stamp_ms  = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    direction;
  logic [STAMP_W-1:0]      event_ms;

  swipe_gesture_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .stamp_ms  (stamp_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .direction (direction),
    .event_ms  (event_ms)
  );

  swipe_scoreboard sb = new();

  // --------------------------------------------------------------------------
  // Report side: check each transaction, then pick the next ready level.
  // The stall pattern is refreshed whenever the 5-bit age counter wraps; the
  // sparse mode keeps bit 0 set so a stall never outlasts one pattern.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_FREE;
  logic [31:0] stall_pattern = '1;
  logic [4:0]  stall_age = '0;

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_report(direction, event_ms);
    if (stall_age == 5'd0) begin
      case (rx_mode)
        RX_PATTERN: stall_pattern <= $urandom | $urandom;
        RX_SPARSE:  stall_pattern <= ($urandom & $urandom & $urandom) | 32'd1;
        default:    stall_pattern <= '1;
      endcase
    end
    stall_age <= stall_age + 5'd1;
    out_ready <= (rx_mode == RX_FREE) ? 1'b1 : stall_pattern[stall_age];
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves a transaction for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sample side drivers
  // --------------------------------------------------------------------------
  bit          idle_on     = 1'b0;
  int          burst_left  = 0;
  int          samples_sent = 0;
  logic [31:0] now_ms      = 32'd10000;

  // Offer one sample and hold it until taken. Valid stays high into the next
  // sample unless a gap between bursts is due.
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [31:0] t);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    stamp_ms <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, y, t);
    samples_sent++;
  endtask

  // Next frame of the running clock, roughly 20 to 50 fps
  task automatic send_frame(input int x, input int y);
    now_ms = now_ms + $urandom_range(20, 50);
    send_sample(x[15:0], y[15:0], now_ms);
  endtask

  // Straight horizontal ramp with a little vertical jitter. A broken one
  // gets a vertical jump, a time jump or a teleport halfway through.
  task automatic swipe_run(input bit broken);
    int frames;
    int x;
    int y;
    int dx;
    frames = $urandom_range(4, 36);
    x  = int'($urandom_range(0, 4000)) - 2000;
    y  = int'($urandom_range(0, 2000)) - 1000;
    dx = int'($urandom_range(1, 60));
    if ($urandom_range(0, 1) == 1) dx = -dx;
    for (int k = 0; k < frames; k++) begin
      if (broken && k == frames / 2) begin
        case ($urandom_range(0, 2))
          0:       y = y + int'($urandom_range(100, 800));
          1:       now_ms = now_ms + $urandom_range(500, 3000);
          default: x = int'($urandom_range(0, 4000)) - 2000;
        endcase
      end
      send_frame(x, y + int'($urandom_range(0, 40)) - 20);
      x = x + dx;
    end
  endtask

  // Hand held still: tiny drift in both axes
  task automatic still_run();
    int x;
    int y;
    x = int'($urandom_range(0, 2000)) - 1000;
    y = int'($urandom_range(0, 2000)) - 1000;
    repeat ($urandom_range(3, 20))
      send_frame(x + int'($urandom_range(0, 6)) - 3, y + int'($urandom_range(0, 6)) - 3);
  endtask

  // Any field value at all, stamp included; sometimes drag the clock along
  task automatic noise_run();
    repeat ($urandom_range(1, 4)) send_sample(16'($urandom), 16'($urandom), $urandom);
    if ($urandom_range(0, 1) == 1) now_ms = $urandom;
  endtask

  // One register write; valid is left to the caller to drop
  task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input int p);
    for (int i = 0; i < 6; i++) write_one(REG_ORDER[i], PHASE_SETTINGS[p][i]);
    cfg_valid <= 1'b0;
  endtask

  // Hold off new samples until every report is in and any scan that yields
  // nothing has surely ended
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int phase_start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes at reset settings, no idling
    send_sample(16'h7FFF, 16'h8000, 32'd0);
    send_sample(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    send_sample(16'h0000, 16'h0000, 32'd1000);

    // Rightward ramp, then a leftward one: reports once the span reaches
    // min_dur, then again only after the gap has passed
    for (int k = 0; k < 8; k++) send_sample(16'(-200 + 40 * k), 16'd0, 32'(2000 + 60 * k));
    for (int k = 0; k < 6; k++) send_sample(16'(300 - 40 * k), 16'd5, 32'(4000 + 70 * k));

    // Dead band: with no travel needed, small backward moves inside the band
    // still count as right, while a move back to its edge counts as left
    drain();
    write_one(REG_MIN_LENGTH, 16'd0);
    cfg_valid <= 1'b0;
    send_sample(16'd10, 16'd0, 32'd6000);
    send_sample(16'd0,  16'd0, 32'd6300);
    send_sample(16'd5,  16'd0, 32'd6700);
    send_sample(16'd1,  16'd0, 32'd7100);

    // Random phases: each one loads a full settings row, picks its own
    // idling style and runs a mix of gesture segments
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(p);
      idle_on = (p % 3 != 1);
      rx_mode <= rx_mode_e'(p % 3);
      phase_start = samples_sent;
      while (samples_sent - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) swipe_run(1'b0);
        else if (pick < 70) swipe_run(1'b1);
        else if (pick < 82) still_run();
        else if (pick < 92) noise_run();
        else begin
          // run the stamp through its wrap point
          now_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
          swipe_run(1'b0);
        end
      end
    end

    drain();
    $display("Run covered %0d samples over %0d register settings: %0d right and %0d left swipes.",
             samples_sent, NUM_PHASES + 2, sb.rights, sb.lefts);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sgd_pkg.sv
rtl/sgd_ctrl.sv
rtl/sgd_dp.sv
rtl/swipe_gesture_detector.sv
test/tb_top.sv
